// ===== design/pmi_pkg.sv =====
// Package for the plane mirror image point block.
// Holds the coordinate widths and the item type passed from the front to the back.
// No dependencies.
package pmi_pkg;

  // Coordinate and difference widths
  localparam int CoordW = 32;
  localparam int DiffW  = CoordW + 1;
  localparam int MagW   = 31;

  // Classified item handed from the front part to the back part
  typedef struct packed {
    logic [2:0][MagW-1:0]  mag;  // normalised normal magnitudes
    logic [2:0]            sgn;  // normal component signs
    logic                  deg;  // zero normal
    logic [2:0][DiffW-1:0] d;    // source minus third corner
    logic [2:0][CoordW-1:0] p;   // source point
  } fb_t;

endpackage

// ===== design/pmi_if.sv =====
// Stream interfaces for the input and result items of the mirror block.
// Depends on pmi_pkg for the coordinate width.

interface pmi_in_if;
  logic valid;
  logic ready;
  logic signed [pmi_pkg::CoordW-1:0] corner0_x, corner0_y, corner0_z;
  logic signed [pmi_pkg::CoordW-1:0] corner1_x, corner1_y, corner1_z;
  logic signed [pmi_pkg::CoordW-1:0] corner2_x, corner2_y, corner2_z;
  logic signed [pmi_pkg::CoordW-1:0] source_x, source_y, source_z;

  modport source (
    output valid, corner0_x, corner0_y, corner0_z, corner1_x, corner1_y, corner1_z,
           corner2_x, corner2_y, corner2_z, source_x, source_y, source_z,
    input  ready
  );
  modport sink (
    input  valid, corner0_x, corner0_y, corner0_z, corner1_x, corner1_y, corner1_z,
           corner2_x, corner2_y, corner2_z, source_x, source_y, source_z,
    output ready
  );
endinterface

interface pmi_out_if;
  logic valid;
  logic ready;
  logic signed [pmi_pkg::CoordW-1:0] image_x, image_y, image_z;
  logic [pmi_pkg::CoordW-2:0]        plane_distance;
  logic                              degenerate;

  modport source (
    output valid, image_x, image_y, image_z, plane_distance, degenerate,
    input  ready
  );
  modport sink (
    input  valid, image_x, image_y, image_z, plane_distance, degenerate,
    output ready
  );
endinterface

// ===== design/pmi_front.sv =====
// Front part: corner differences, cross product and block normalisation of the normal.
// Depends on pmi_pkg and pmi_in_if. Seven pipeline stages, one item per cycle unless stalled.
module pmi_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  pmi_in_if.sink         in_i,
  output logic           valid_o,
  output pmi_pkg::fb_t   item_o,
  input  logic           ready_i
);

  localparam int NS = 7;

  logic [NS-1:0] vld_q;
  logic          adv;

  // Carried source point and source-to-corner difference
  logic signed [2:0][pmi_pkg::DiffW-1:0]  dc_q [NS-1];
  logic signed [2:0][pmi_pkg::CoordW-1:0] pc_q [NS-1];

  logic signed [pmi_pkg::DiffW-1:0] uu_q [3];
  logic signed [pmi_pkg::DiffW-1:0] vv_q [3];
  logic signed [65:0] pr_q [6];
  logic signed [66:0] n_q  [3];
  logic [65:0]        a_q  [3];
  logic [2:0]         sg_q;
  logic [65:0]        ow_q;
  logic [65:0]        a5_q [3];
  logic [2:0]         sg5_q;
  logic               dg5_q;
  logic [3:0]         grp_q;
  logic [7:0]         byt_q;
  logic [65:0]        a6_q [3];
  logic [2:0]         sg6_q;
  logic               dg6_q;
  logic [6:0]         len_q;
  pmi_pkg::fb_t       item_q;

  logic signed [pmi_pkg::CoordW-1:0] c0 [3], c1 [3], c2 [3], ps [3];
  logic [71:0] pw;
  logic [3:0]  grp_d;
  logic [7:0]  byt_d;
  logic [3:0]  bl;

  assign c0 = '{in_i.corner0_x, in_i.corner0_y, in_i.corner0_z};
  assign c1 = '{in_i.corner1_x, in_i.corner1_y, in_i.corner1_z};
  assign c2 = '{in_i.corner2_x, in_i.corner2_y, in_i.corner2_z};
  assign ps = '{in_i.source_x, in_i.source_y, in_i.source_z};

  // Advance the whole pipe unless the last item is stalled
  assign adv       = ~vld_q[NS-1] | ready_i;
  assign in_i.ready = adv;
  assign valid_o   = vld_q[NS-1];
  assign item_o    = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], in_i.valid};
    end
  end

  // Find the top non-zero byte of the magnitude OR word
  always_comb begin
    pw    = {6'b0, ow_q};
    grp_d = '0;
    byt_d = '0;
    for (int g = 0; g < 9; g++) begin
      if (pw[g*8 +: 8] != 8'd0) begin
        grp_d = 4'(g);
        byt_d = pw[g*8 +: 8];
      end
    end
  end

  // Bit length within the top byte
  always_comb begin
    bl = '0;
    for (int b = 0; b < 8; b++) begin
      if (byt_q[b]) bl = 4'(b + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Stage 1: differences
      for (int j = 0; j < 3; j++) begin
        uu_q[j]    <= {c1[j][31], c1[j]} - {c0[j][31], c0[j]};
        vv_q[j]    <= {c2[j][31], c2[j]} - {c0[j][31], c0[j]};
        dc_q[0][j] <= {ps[j][31], ps[j]} - {c2[j][31], c2[j]};
        pc_q[0][j] <= ps[j];
      end
      for (int k = 1; k < NS - 1; k++) begin
        dc_q[k] <= dc_q[k-1];
        pc_q[k] <= pc_q[k-1];
      end
      // Stage 2: cross product terms
      pr_q[0] <= uu_q[1] * vv_q[2];
      pr_q[1] <= uu_q[2] * vv_q[1];
      pr_q[2] <= uu_q[2] * vv_q[0];
      pr_q[3] <= uu_q[0] * vv_q[2];
      pr_q[4] <= uu_q[0] * vv_q[1];
      pr_q[5] <= uu_q[1] * vv_q[0];
      // Stage 3: normal components
      for (int j = 0; j < 3; j++) begin
        n_q[j] <= {pr_q[2*j][65], pr_q[2*j]} - {pr_q[2*j+1][65], pr_q[2*j+1]};
      end
      // Stage 4: magnitudes and signs
      for (int j = 0; j < 3; j++) begin
        a_q[j]  <= n_q[j][66] ? 66'(-n_q[j]) : n_q[j][65:0];
        sg_q[j] <= n_q[j][66];
      end
      ow_q <= (n_q[0][66] ? 66'(-n_q[0]) : n_q[0][65:0])
            | (n_q[1][66] ? 66'(-n_q[1]) : n_q[1][65:0])
            | (n_q[2][66] ? 66'(-n_q[2]) : n_q[2][65:0]);
      // Stage 5: top byte
      a5_q  <= a_q;
      sg5_q <= sg_q;
      dg5_q <= (ow_q == 66'd0);
      grp_q <= grp_d;
      byt_q <= byt_d;
      // Stage 6: bit length
      a6_q  <= a5_q;
      sg6_q <= sg5_q;
      dg6_q <= dg5_q;
      len_q <= {grp_q[3:0], 3'b000} + 7'(bl);
      // Stage 7: shift the largest magnitude into [2^30, 2^31)
      for (int j = 0; j < 3; j++) begin
        if (len_q > 7'd31) begin
          item_q.mag[j] <= 31'(a6_q[j] >> (len_q - 7'd31));
        end else begin
          item_q.mag[j] <= 31'(a6_q[j] << (7'd31 - len_q));
        end
      end
      item_q.sgn <= sg6_q;
      item_q.deg <= dg6_q;
      item_q.d   <= dc_q[NS-2];
      item_q.p   <= pc_q[NS-2];
    end
  end

endmodule

// ===== design/pmi_queue.sv =====
// Short queue between the front and back parts.
// Depends on pmi_pkg for the item type.
module pmi_queue #(
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  pmi_pkg::fb_t item_i,
  output logic         ready_o,
  output logic         valid_o,
  output pmi_pkg::fb_t item_o,
  input  logic         ready_i
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  pmi_pkg::fb_t mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic push, pop;

  assign ready_o = (cnt_q != CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rp_q];
  assign push    = valid_i & ready_o;
  assign pop     = valid_o & ready_i;

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Store an item
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= item_i;
  end

endmodule

// ===== design/pmi_back.sv =====
// Back part: normal length by square root, unit normal by division, distance and image.
// Depends on pmi_pkg and pmi_out_if. 73 pipeline stages, one item per cycle unless stalled.
module pmi_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  pmi_pkg::fb_t item_i,
  output logic         ready_o,
  pmi_out_if.source    out_o
);

  localparam int NB    = 73;
  localparam int SQ_N  = 32;  // root bits
  localparam int DV_N  = 31;  // quotient bits
  localparam int P_SQ  = 33;  // last square root stage
  localparam int P_DV  = 65;  // last division stage
  localparam logic signed [36:0] SatHi = 37'sd2147483647;
  localparam logic signed [36:0] SatLo = -37'sd2147483648;

  logic [NB-1:0] vld_q;
  logic          adv;
  pmi_pkg::fb_t  it_q [NB];

  logic [61:0] sq_q [3];
  logic [63:0] sm_q [SQ_N+1];
  logic [31:0] rt_q [SQ_N+1];
  logic [35:0] rm_q [SQ_N+1];
  logic [31:0] rr_q [DV_N+1];
  logic [61:0] nm_q [DV_N+1][3];
  logic [31:0] dr_q [DV_N+1][3];
  logic [30:0] dq_q [DV_N+1][3];
  logic signed [31:0] nh_q [4][3];
  logic signed [64:0] dp_q [3];
  logic signed [66:0] acc_q;
  logic signed [35:0] s_q [3];
  logic signed [67:0] sn_q [3];
  logic signed [35:0] t_q [3];
  logic signed [pmi_pkg::CoordW-1:0] img_q [3];
  logic [pmi_pkg::CoordW-2:0] dist_q;
  logic deg_q;

  logic [61:0] num_w [3];

  // Round v / 2^30 to nearest, ties away from zero
  function automatic logic signed [35:0] round_s(input logic signed [66:0] v);
    logic [66:0] m;
    logic [66:0] r;
    m = v[66] ? 67'(-v) : v;
    r = (m + (67'd1 << 29)) >> 30;
    return v[66] ? -$signed(r[35:0]) : $signed(r[35:0]);
  endfunction

  // Round v / 2^29 to nearest, ties away from zero
  function automatic logic signed [35:0] round_t(input logic signed [67:0] v);
    logic [67:0] m;
    logic [67:0] r;
    m = v[67] ? 68'(-v) : v;
    r = (m + (68'd1 << 28)) >> 29;
    return v[67] ? -$signed(r[35:0]) : $signed(r[35:0]);
  endfunction

  assign adv     = ~vld_q[NB-1] | out_o.ready;
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NB-2:0], valid_i};
    end
  end

  // Carry the item alongside the arithmetic
  always_ff @(posedge clk_i) begin
    if (adv) begin
      it_q[0] <= item_i;
      for (int k = 1; k < NB; k++) it_q[k] <= it_q[k-1];
    end
  end

  // Squares, their sum and the root seed
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) sq_q[j] <= item_i.mag[j] * item_i.mag[j];
      sm_q[0] <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
      rt_q[0] <= '0;
      rm_q[0] <= '0;
    end
  end

  // Square root, one root bit per stage
  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    logic [35:0] tr, trial;
    logic        ge;
    assign tr    = {rm_q[k][33:0], sm_q[k][2*(SQ_N-1-k)+1 -: 2]};
    assign trial = {2'b00, rt_q[k], 2'b01};
    assign ge    = (tr >= trial);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sm_q[k+1] <= sm_q[k];
        rt_q[k+1] <= {rt_q[k][30:0], ge};
        rm_q[k+1] <= ge ? tr - trial : tr;
      end
    end
  end

  // Numerators: magnitude scaled to Q2.30 plus half the length
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      num_w[j] = {1'b0, it_q[P_SQ].mag[j], 30'b0} + 62'(rt_q[SQ_N] >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rr_q[0] <= rt_q[SQ_N];
      for (int j = 0; j < 3; j++) begin
        nm_q[0][j] <= num_w[j];
        dr_q[0][j] <= {1'b0, num_w[j][61:31]};
        dq_q[0][j] <= '0;
      end
    end
  end

  // Three dividers, one quotient bit per stage
  for (genvar k = 0; k < DV_N; k++) begin : g_div
    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [32:0] tr;
      logic        ge;
      assign tr = {dr_q[k][j], nm_q[k][j][DV_N-1-k]};
      assign ge = (tr >= {1'b0, rr_q[k]});
      always_ff @(posedge clk_i) begin
        if (adv) begin
          nm_q[k+1][j] <= nm_q[k][j];
          dr_q[k+1][j] <= ge ? 32'(tr - {1'b0, rr_q[k]}) : tr[31:0];
          dq_q[k+1][j] <= {dq_q[k][j][29:0], ge};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) rr_q[k+1] <= rr_q[k];
    end
  end

  // Unit normal, distance, image and saturation
  always_ff @(posedge clk_i) begin
    logic signed [36:0] df;
    logic [35:0]        sm;
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        nh_q[0][j] <= it_q[P_DV].sgn[j] ? -$signed({1'b0, dq_q[DV_N][j]})
                                        : $signed({1'b0, dq_q[DV_N][j]});
      end
      for (int k = 1; k < 4; k++) nh_q[k] <= nh_q[k-1];
      for (int j = 0; j < 3; j++) dp_q[j] <= nh_q[0][j] * $signed(it_q[66].d[j]);
      acc_q <= 67'(dp_q[0]) + 67'(dp_q[1]) + 67'(dp_q[2]);
      s_q[0] <= round_s(acc_q);
      s_q[1] <= s_q[0];
      s_q[2] <= s_q[1];
      for (int j = 0; j < 3; j++) sn_q[j] <= s_q[0] * nh_q[3][j];
      for (int j = 0; j < 3; j++) t_q[j] <= round_t(sn_q[j]);
      for (int j = 0; j < 3; j++) begin
        df = 37'($signed(it_q[71].p[j])) - 37'(t_q[j]);
        if (it_q[71].deg) img_q[j] <= $signed(it_q[71].p[j]);
        else if (df > SatHi) img_q[j] <= SatHi[31:0];
        else if (df < SatLo) img_q[j] <= SatLo[31:0];
        else img_q[j] <= df[31:0];
      end
      sm = s_q[2][35] ? 36'(-s_q[2]) : s_q[2];
      if (it_q[71].deg) dist_q <= '0;
      else if (sm > 36'h07FFFFFFF) dist_q <= 31'h7FFFFFFF;
      else dist_q <= sm[30:0];
      deg_q <= it_q[71].deg;
    end
  end

  assign out_o.valid          = vld_q[NB-1];
  assign out_o.image_x        = img_q[0];
  assign out_o.image_y        = img_q[1];
  assign out_o.image_z        = img_q[2];
  assign out_o.plane_distance = dist_q;
  assign out_o.degenerate     = deg_q;

endmodule

// ===== design/plane_mirror_image_point.sv =====
// Mirrors a point across the plane through three corners, one item per clock cycle
// sustained while the output is not stalled. The front part (7 stages) forms and
// normalises the normal; a queue of QUEUE_DEPTH items decouples it from the back part
// (73 stages: a 32-stage square root, three 31-stage dividers, dot product, image and
// saturation). Throughput is set by the fully pipelined root and divider stages, each
// resolving one bit per cycle.
// Depends on pmi_pkg, pmi_if, pmi_front, pmi_queue and pmi_back.
module plane_mirror_image_point #(
  parameter int QUEUE_DEPTH = 4  // 2 or more
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pmi_in_if.sink   in_i,
  pmi_out_if.source out_o
);

  logic         fq_valid, fq_ready;
  pmi_pkg::fb_t fq_item;
  logic         qb_valid, qb_ready;
  pmi_pkg::fb_t qb_item;

  // Classify and normalise
  pmi_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (fq_valid),
    .item_o  (fq_item),
    .ready_i (fq_ready)
  );

  // Decouple the two parts
  pmi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fq_valid),
    .item_i  (fq_item),
    .ready_o (fq_ready),
    .valid_o (qb_valid),
    .item_o  (qb_item),
    .ready_i (qb_ready)
  );

  // Root, divide, reflect
  pmi_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (qb_valid),
    .item_i  (qb_item),
    .ready_o (qb_ready),
    .out_o   (out_o)
  );

  // A degenerate result carries zero distance
  a_deg_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.degenerate |-> out_o.plane_distance == '0)
    else $error("degenerate result with non-zero distance");

  // A stalled front item holds until the queue takes it
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_valid && !fq_ready |=> fq_valid && $stable(fq_item))
    else $error("front item dropped or changed while stalled");

  // The queue head holds while the back part stalls
  a_queue_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qb_valid && !qb_ready |=> qb_valid && $stable(qb_item))
    else $error("queue head dropped or changed while stalled");

endmodule
